[rtl/point_segment_distance_core_assert.svh]
// ---------------------------------------------------------------------------
// point segment distance assertion macros
// concurrent property checks, empty when synthesized
// ---------------------------------------------------------------------------
`ifndef POINT_SEGMENT_DISTANCE_CORE_ASSERT_SVH
`define POINT_SEGMENT_DISTANCE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// property holds in the same cycle
`define PSD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("psd assertion failed");
// consequent holds in the cycle after the antecedent
`define PSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("psd assertion failed");
`else
`define PSD_ASSERT(lbl, clk, rstn, prop)
`define PSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[rtl/psd_pkg.sv]
// ---------------------------------------------------------------------------
// psd_pkg
// shared widths, types and region codes of the point segment distance core
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package psd_pkg;

  localparam int CoordBits = 24;
  localparam int TBits     = 16;
  localparam int DistBits  = 25;
  // coordinate differences
  localparam int DiffW = CoordBits + 1;
  localparam int ProdW = 2 * DiffW;
  localparam int Len2W = ProdW + 1;
  localparam int RemW  = Len2W + 1;
  // offset vector and squared distance
  localparam int UW    = DiffW + 2;
  localparam int SqW   = 2 * UW;
  localparam int NW    = SqW + 2;
  localparam int RootW = NW / 2;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [DiffW-1:0]     diff_t;

  typedef enum logic [1:0] {
    REG_INTERIOR = 2'd0,
    REG_BEFORE   = 2'd1,
    REG_PAST     = 2'd2,
    REG_DEGEN    = 2'd3
  } region_e;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    coord_t point_x;
    coord_t point_y;
  } in_t;

  typedef struct packed {
    logic [DistBits-1:0] distance;
    region_e             region;
  } out_t;

  // values carried alongside the projection divider
  typedef struct packed {
    region_e region;
    logic    eq;
    diff_t   dx;
    diff_t   dy;
    diff_t   qx;
    diff_t   qy;
    diff_t   rx;
    diff_t   ry;
  } div_side_t;

endpackage

[rtl/point_segment_distance_core.sv]
// ---------------------------------------------------------------------------
// point_segment_distance_core
// distance from a query point to a line segment, with region code
// ---------------------------------------------------------------------------
// Takes one beat per clock while in_stall_o is low and returns one beat per
// input beat, in order. The path from input acceptance to the output register
// is four setup stages, a 16-stage projection divider, four offset and square
// stages, and a 28-stage square root, then the output register. A two-entry
// output buffer absorbs one result while the output stalls; while its second
// entry is full, in_stall_o is high and the pipeline holds.
`timescale 1ns / 1ps
`include "point_segment_distance_core_assert.svh"
module point_segment_distance_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  psd_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output psd_pkg::out_t  out_data_o
);

  localparam int MulW = psd_pkg::TBits + 2 + psd_pkg::DiffW;

  logic en;
  logic skid_full_q;
  logic out_valid_q;
  psd_pkg::out_t out_q, skid_q;

  assign en = !skid_full_q;

  // stage a: differences
  logic va_q;
  psd_pkg::diff_t dx_a, dy_a, qx_a, qy_a, rx_a, ry_a;
  // stage b: products
  logic vb_q, deg_b;
  logic signed [psd_pkg::ProdW-1:0] dxx_b, dyy_b, qdx_b, qdy_b;
  psd_pkg::diff_t dx_b, dy_b, qx_b, qy_b, rx_b, ry_b;
  // stage c: sums
  logic vc_q, deg_c;
  logic signed [psd_pkg::Len2W-1:0] len2_c, dot_c;
  psd_pkg::diff_t dx_c, dy_c, qx_c, qy_c, rx_c, ry_c;
  // stage d: region decision
  logic vd_q;
  logic [psd_pkg::Len2W-1:0] len2_d, dot_d;
  psd_pkg::div_side_t side_d;
  // divider output
  logic vdiv;
  logic [psd_pkg::TBits-1:0] quo;
  psd_pkg::div_side_t side_div;
  // stage e: projection products
  logic ve_q;
  logic signed [MulW-1:0] px_e, py_e;
  psd_pkg::div_side_t side_e;
  // stage f: offset vector
  logic vf_q;
  logic signed [psd_pkg::UW-1:0] ux_f, uy_f;
  psd_pkg::region_e reg_f;
  // stage g: squares
  logic vg_q;
  logic signed [psd_pkg::SqW-1:0] sx_g, sy_g;
  psd_pkg::region_e reg_g;
  // stage h: squared distance
  logic vh_q;
  logic [psd_pkg::NW-1:0] n_h;
  psd_pkg::region_e reg_h;
  // root output
  logic vroot;
  logic [psd_pkg::RootW-1:0] root;
  psd_pkg::region_e reg_root;

  logic [psd_pkg::TBits:0] t_e;
  psd_pkg::region_e reg_dc;
  logic signed [psd_pkg::UW-1:0] ox_f, oy_f;
  psd_pkg::out_t res;
  logic push, pop;

  // region from projection sign and magnitude
  always_comb begin
    if (deg_c) begin
      reg_dc = psd_pkg::REG_DEGEN;
    end else if (dot_c < 0) begin
      reg_dc = psd_pkg::REG_BEFORE;
    end else if (dot_c > len2_c) begin
      reg_dc = psd_pkg::REG_PAST;
    end else begin
      reg_dc = psd_pkg::REG_INTERIOR;
    end
  end

  // t is exactly one when the projection lands on the end point
  assign t_e  = side_div.eq ? (psd_pkg::TBits + 1)'(1) << psd_pkg::TBits : {1'b0, quo};
  assign ox_f = px_e[MulW-1:psd_pkg::TBits];
  assign oy_f = py_e[MulW-1:psd_pkg::TBits];

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vg_q <= 1'b0;
      vh_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vdiv;
      vf_q <= ve_q;
      vg_q <= vf_q;
      vh_q <= vg_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_a <= psd_pkg::diff_t'(in_data_i.end_x) - psd_pkg::diff_t'(in_data_i.start_x);
      dy_a <= psd_pkg::diff_t'(in_data_i.end_y) - psd_pkg::diff_t'(in_data_i.start_y);
      qx_a <= psd_pkg::diff_t'(in_data_i.point_x) - psd_pkg::diff_t'(in_data_i.start_x);
      qy_a <= psd_pkg::diff_t'(in_data_i.point_y) - psd_pkg::diff_t'(in_data_i.start_y);
      rx_a <= psd_pkg::diff_t'(in_data_i.point_x) - psd_pkg::diff_t'(in_data_i.end_x);
      ry_a <= psd_pkg::diff_t'(in_data_i.point_y) - psd_pkg::diff_t'(in_data_i.end_y);

      dxx_b <= dx_a * dx_a;
      dyy_b <= dy_a * dy_a;
      qdx_b <= qx_a * dx_a;
      qdy_b <= qy_a * dy_a;
      deg_b <= (dx_a == '0) && (dy_a == '0);
      dx_b <= dx_a; dy_b <= dy_a; qx_b <= qx_a; qy_b <= qy_a; rx_b <= rx_a; ry_b <= ry_a;

      len2_c <= psd_pkg::Len2W'(dxx_b) + psd_pkg::Len2W'(dyy_b);
      dot_c  <= psd_pkg::Len2W'(qdx_b) + psd_pkg::Len2W'(qdy_b);
      deg_c  <= deg_b;
      dx_c <= dx_b; dy_c <= dy_b; qx_c <= qx_b; qy_c <= qy_b; rx_c <= rx_b; ry_c <= ry_b;

      len2_d        <= len2_c;
      dot_d         <= dot_c;
      side_d.region <= reg_dc;
      side_d.eq     <= dot_c == len2_c;
      side_d.dx <= dx_c; side_d.dy <= dy_c; side_d.qx <= qx_c;
      side_d.qy <= qy_c; side_d.rx <= rx_c; side_d.ry <= ry_c;

      px_e   <= $signed({1'b0, t_e}) * side_div.dx;
      py_e   <= $signed({1'b0, t_e}) * side_div.dy;
      side_e <= side_div;

      // pick the vector to the nearest point of the segment
      unique case (side_e.region)
        psd_pkg::REG_INTERIOR: begin
          ux_f <= psd_pkg::UW'(side_e.qx) - ox_f;
          uy_f <= psd_pkg::UW'(side_e.qy) - oy_f;
        end
        psd_pkg::REG_PAST: begin
          ux_f <= psd_pkg::UW'(side_e.rx);
          uy_f <= psd_pkg::UW'(side_e.ry);
        end
        default: begin
          ux_f <= psd_pkg::UW'(side_e.qx);
          uy_f <= psd_pkg::UW'(side_e.qy);
        end
      endcase
      reg_f <= side_e.region;

      sx_g  <= ux_f * ux_f;
      sy_g  <= uy_f * uy_f;
      reg_g <= reg_f;

      n_h   <= psd_pkg::NW'(unsigned'(sx_g)) + psd_pkg::NW'(unsigned'(sy_g));
      reg_h <= reg_g;
    end
  end

  psd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vd_q),
    .len2_i  (len2_d),
    .dot_i   (dot_d),
    .side_i  (side_d),
    .valid_o (vdiv),
    .quo_o   (quo),
    .side_o  (side_div)
  );

  psd_sqrt u_sqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (vh_q),
    .n_i      (n_h),
    .region_i (reg_h),
    .valid_o  (vroot),
    .root_o   (root),
    .region_o (reg_root)
  );

  // saturate the root to the output width
  assign res.distance = (root > psd_pkg::RootW'({psd_pkg::DistBits{1'b1}})) ?
                        {psd_pkg::DistBits{1'b1}} : root[psd_pkg::DistBits-1:0];
  assign res.region   = reg_root;

  assign push = en && vroot;
  assign pop  = out_valid_q && !out_stall_i;

  // two-entry output buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (skid_full_q) begin
      if (pop) skid_full_q <= 1'b0;
    end else if (push) begin
      if (out_valid_q && !pop) skid_full_q <= 1'b1;
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_full_q) begin
      if (pop) out_q <= skid_q;
    end else if (push) begin
      if (out_valid_q && !pop) skid_q <= res;
      else                     out_q  <= res;
    end
  end

  assign in_stall_o  = skid_full_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `PSD_ASSERT(a_skid_has_head, clk_i, rst_ni, !skid_full_q || out_valid_q)
  `PSD_ASSERT_NEXT(a_skid_drains, clk_i, rst_ni, skid_full_q && !out_stall_i, !skid_full_q && out_valid_q)

endmodule

[rtl/psd_div.sv]
// ---------------------------------------------------------------------------
// psd_div
// pipelined restoring divider, one quotient bit per stage
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module psd_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic [psd_pkg::Len2W-1:0]            len2_i,
  input  logic [psd_pkg::Len2W-1:0]            dot_i,
  input  psd_pkg::div_side_t                   side_i,
  output logic                                 valid_o,
  output logic [psd_pkg::TBits-1:0]            quo_o,
  output psd_pkg::div_side_t                   side_o
);

  localparam int N = psd_pkg::TBits;

  logic [N-1:0]                  v_q;
  logic [psd_pkg::RemW-1:0]      rem_q  [N];
  logic [psd_pkg::Len2W-1:0]     len_q  [N];
  logic [N-1:0]                  quo_q  [N];
  psd_pkg::div_side_t            side_q [N];

  logic [psd_pkg::RemW-1:0]      rem_in [N];
  logic [psd_pkg::Len2W-1:0]     len_in [N];
  logic [N-1:0]                  quo_in [N];
  psd_pkg::div_side_t            side_in[N];
  logic [psd_pkg::RemW-1:0]      rem_sh [N];
  logic [N-1:0]                  trial;
  logic [psd_pkg::RemW-1:0]      rem_d  [N];
  logic [N-1:0]                  quo_d  [N];

  // one shift and trial subtract per stage
  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        rem_in[k]  = {1'b0, dot_i};
        len_in[k]  = len2_i;
        quo_in[k]  = '0;
        side_in[k] = side_i;
      end else begin
        rem_in[k]  = rem_q[k-1];
        len_in[k]  = len_q[k-1];
        quo_in[k]  = quo_q[k-1];
        side_in[k] = side_q[k-1];
      end
      rem_sh[k] = rem_in[k] << 1;
      trial[k]  = rem_sh[k] >= {1'b0, len_in[k]};
      rem_d[k]  = trial[k] ? rem_sh[k] - {1'b0, len_in[k]} : rem_sh[k];
      quo_d[k]  = {quo_in[k][N-2:0], trial[k]};
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[N-2:0], valid_i};
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < N; k++) begin
        rem_q[k]  <= rem_d[k];
        len_q[k]  <= len_in[k];
        quo_q[k]  <= quo_d[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign quo_o   = quo_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

[rtl/psd_sqrt.sv]
// ---------------------------------------------------------------------------
// psd_sqrt
// pipelined integer square root, one root bit per stage
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module psd_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [psd_pkg::NW-1:0]        n_i,
  input  psd_pkg::region_e              region_i,
  output logic                          valid_o,
  output logic [psd_pkg::RootW-1:0]     root_o,
  output psd_pkg::region_e              region_o
);

  localparam int N = psd_pkg::RootW;

  logic [N-1:0]               v_q;
  logic [psd_pkg::NW-1:0]     n_q   [N];
  logic [psd_pkg::NW-1:0]     res_q [N];
  psd_pkg::region_e           reg_q [N];

  logic [psd_pkg::NW-1:0]     n_in  [N];
  logic [psd_pkg::NW-1:0]     res_in[N];
  psd_pkg::region_e           reg_in[N];
  logic [psd_pkg::NW-1:0]     bitv  [N];
  logic [psd_pkg::NW-1:0]     sum   [N];
  logic [psd_pkg::NW-1:0]     n_d   [N];
  logic [psd_pkg::NW-1:0]     res_d [N];

  // compare remainder against root plus trial bit
  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        n_in[k]   = n_i;
        res_in[k] = '0;
        reg_in[k] = region_i;
      end else begin
        n_in[k]   = n_q[k-1];
        res_in[k] = res_q[k-1];
        reg_in[k] = reg_q[k-1];
      end
      bitv[k] = psd_pkg::NW'(1) << (2 * (N - 1 - k));
      sum[k]  = res_in[k] + bitv[k];
      if (n_in[k] >= sum[k]) begin
        n_d[k]   = n_in[k] - sum[k];
        res_d[k] = (res_in[k] >> 1) + bitv[k];
      end else begin
        n_d[k]   = n_in[k];
        res_d[k] = res_in[k] >> 1;
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[N-2:0], valid_i};
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < N; k++) begin
        n_q[k]   <= n_d[k];
        res_q[k] <= res_d[k];
        reg_q[k] <= reg_in[k];
      end
    end
  end

  assign valid_o  = v_q[N-1];
  assign root_o   = res_q[N-1][N-1:0];
  assign region_o = reg_q[N-1];

endmodule
